// File: rtl/core/ucc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types and constants of the user-ID certification counter: opcodes,
// trust levels, trusted-key table geometry and the lookup status word.
// ----------------------------------------------------------------------------
package ucc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int TBL_CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 64;
  localparam int LVL_W       = 3;
  localparam int CNT_W       = 8;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [TBL_CNT_W-1:0] TBL_FULL = TBL_CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]     CNT_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_NEEDED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGINAL_NEEDED = 1'b1;

  localparam logic [CNT_W-1:0] FULL_NEEDED_RST     = 8'd1;
  localparam logic [CNT_W-1:0] MARGINAL_NEEDED_RST = 8'd3;

  localparam logic [LVL_W-1:0] LVL_MARGINAL = 3'd2;
  localparam logic [LVL_W-1:0] LVL_FULLY    = 3'd3;
  localparam logic [LVL_W-1:0] LVL_ULTIMATE = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_UID    = 3'd3,
    OP_SIG    = 3'd4,
    OP_END    = 3'd5
  } op_t;

  typedef enum logic {
    LKP_IDLE,
    LKP_SCAN
  } lkp_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [LVL_W-1:0] level;
  } tbl_entry_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             hit;
    logic [LVL_W-1:0] level;
  } lkp_status_t;

endpackage

// File: rtl/core/uid_certification_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_certification_counter
// Counts trusted certifications per user ID of a keyblock against a table of
// trusted signer key IDs and reports validity flags as each user ID or keyblock closes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_stall  | op, key_id, trust_level, is_cert
//   out     | output    | out_valid/out_stall| uid flags, keyblock_done, overflow
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A certification by a non-primary key with a non-empty table scans the table
// one entry per cycle through the single read port. Reset clears all control
// state; table contents are not cleared, and no entry at or above the fill
// count is ever read. The result sits in an output register; input stalls only
// during a scan or when a new result meets a result still held by out_stall.
// ----------------------------------------------------------------------------
module uid_certification_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ucc_pkg::OP_W-1:0]          in_op,
  input  logic [ucc_pkg::KEY_W-1:0]         in_key_id,
  input  logic [ucc_pkg::LVL_W-1:0]         in_trust_level,
  input  logic                              in_is_certification,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_uid_present,
  output logic [ucc_pkg::CNT_W-1:0]         out_uid_number,
  output logic                              out_uid_signed,
  output logic                              out_uid_marginal,
  output logic                              out_uid_full,
  output logic                              out_keyblock_done,
  output logic                              out_keyblock_signed,
  output logic                              out_table_overflow,
  input  logic                              cfg_we,
  input  logic [ucc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ucc_pkg::CNT_W-1:0]         cfg_data
);

  ucc_pkg::op_t                  op;
  ucc_pkg::lkp_status_t          lkp;
  ucc_pkg::tbl_entry_t           rd_data;
  ucc_pkg::tbl_entry_t           wr_data;
  logic [ucc_pkg::TBL_AW-1:0]    rd_addr;
  logic                          rd_en;
  logic                          wr_en;

  logic [ucc_pkg::CNT_W-1:0]     full_needed_r;
  logic [ucc_pkg::CNT_W-1:0]     marginal_needed_r;
  logic [ucc_pkg::TBL_CNT_W-1:0] table_count_r;
  logic                          overflow_r;
  logic [ucc_pkg::KEY_W-1:0]     primary_id_r;
  logic                          uid_open_r;
  logic [ucc_pkg::CNT_W-1:0]     uid_ordinal_r;
  logic                          signed_seen_r;
  logic [ucc_pkg::CNT_W-1:0]     full_count_r;
  logic [ucc_pkg::CNT_W-1:0]     marginal_count_r;
  logic                          keyblock_signed_r;

  logic                          out_valid_r;
  logic                          out_uid_present_r;
  logic [ucc_pkg::CNT_W-1:0]     out_uid_number_r;
  logic                          out_uid_signed_r;
  logic                          out_uid_marginal_r;
  logic                          out_uid_full_r;
  logic                          out_keyblock_done_r;
  logic                          out_keyblock_signed_r;
  logic                          out_table_overflow_r;

  logic                          accept;
  logic                          gives_result;
  logic                          lkp_start;
  logic                          uid_full;
  logic                          uid_marg;
  logic                          table_full;

  assign op         = ucc_pkg::op_t'(in_op);
  assign table_full = (table_count_r == ucc_pkg::TBL_FULL);

  assign gives_result = (op == ucc_pkg::OP_END) || (op == ucc_pkg::OP_UID && uid_open_r);
  assign in_stall     = lkp.busy || (out_valid_r && out_stall && gives_result);
  assign accept       = in_valid && !in_stall;

  assign lkp_start = accept && (op == ucc_pkg::OP_SIG) && in_is_certification &&
                     (in_key_id != primary_id_r) && (table_count_r != '0);

  assign uid_full = signed_seen_r &&
                    (full_count_r >= full_needed_r || marginal_count_r >= marginal_needed_r);
  assign uid_marg = signed_seen_r && !uid_full &&
                    (full_count_r != '0 || marginal_count_r != '0);

  assign wr_en           = accept && (op == ucc_pkg::OP_APPEND) && !table_full;
  assign wr_data.id      = in_key_id;
  assign wr_data.level   = in_trust_level;

  ucc_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (table_count_r[ucc_pkg::TBL_AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ucc_lookup u_lookup (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lkp_start),
    .key     (in_key_id),
    .count   (table_count_r),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .status  (lkp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_needed_r     <= ucc_pkg::FULL_NEEDED_RST;
      marginal_needed_r <= ucc_pkg::MARGINAL_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ucc_pkg::REG_FULL_NEEDED:     full_needed_r     <= cfg_data;
        ucc_pkg::REG_MARGINAL_NEEDED: marginal_needed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // keyblock and user-ID state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_count_r     <= '0;
      overflow_r        <= 1'b0;
      primary_id_r      <= '0;
      uid_open_r        <= 1'b0;
      uid_ordinal_r     <= '0;
      signed_seen_r     <= 1'b0;
      full_count_r      <= '0;
      marginal_count_r  <= '0;
      keyblock_signed_r <= 1'b0;
    end else if (lkp.done) begin
      if (lkp.hit) begin
        signed_seen_r <= 1'b1;
        unique case (lkp.level)
          ucc_pkg::LVL_ULTIMATE: begin
            full_count_r <= full_needed_r;
          end
          ucc_pkg::LVL_FULLY: begin
            if (full_count_r != ucc_pkg::CNT_MAX) begin
              full_count_r <= full_count_r + 1'b1;
            end
          end
          ucc_pkg::LVL_MARGINAL: begin
            if (marginal_count_r != ucc_pkg::CNT_MAX) begin
              marginal_count_r <= marginal_count_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else if (accept) begin
      unique case (op)
        ucc_pkg::OP_CLEAR: begin
          table_count_r <= '0;
        end
        ucc_pkg::OP_APPEND: begin
          if (table_full) begin
            overflow_r <= 1'b1;
          end else begin
            table_count_r <= table_count_r + 1'b1;
          end
        end
        ucc_pkg::OP_BEGIN: begin
          primary_id_r      <= in_key_id;
          uid_open_r        <= 1'b0;
          uid_ordinal_r     <= '0;
          signed_seen_r     <= 1'b0;
          full_count_r      <= '0;
          marginal_count_r  <= '0;
          keyblock_signed_r <= 1'b0;
        end
        ucc_pkg::OP_UID: begin
          if (uid_open_r) begin
            keyblock_signed_r <= keyblock_signed_r | signed_seen_r;
            if (uid_ordinal_r != ucc_pkg::CNT_MAX) begin
              uid_ordinal_r <= uid_ordinal_r + 1'b1;
            end
          end else begin
            uid_open_r    <= 1'b1;
            uid_ordinal_r <= '0;
          end
          signed_seen_r    <= 1'b0;
          full_count_r     <= '0;
          marginal_count_r <= '0;
        end
        ucc_pkg::OP_END: begin
          uid_open_r        <= 1'b0;
          uid_ordinal_r     <= '0;
          signed_seen_r     <= 1'b0;
          full_count_r      <= '0;
          marginal_count_r  <= '0;
          keyblock_signed_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && gives_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && gives_result) begin
      out_uid_present_r     <= uid_open_r;
      out_uid_number_r      <= uid_open_r ? uid_ordinal_r : '0;
      out_uid_signed_r      <= uid_open_r && signed_seen_r;
      out_uid_marginal_r    <= uid_open_r && uid_marg;
      out_uid_full_r        <= uid_open_r && uid_full;
      out_keyblock_done_r   <= (op == ucc_pkg::OP_END);
      out_keyblock_signed_r <= (op == ucc_pkg::OP_END) &&
                               (keyblock_signed_r || (uid_open_r && signed_seen_r));
      out_table_overflow_r  <= overflow_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_uid_present     = out_uid_present_r;
  assign out_uid_number      = out_uid_number_r;
  assign out_uid_signed      = out_uid_signed_r;
  assign out_uid_marginal    = out_uid_marginal_r;
  assign out_uid_full        = out_uid_full_r;
  assign out_keyblock_done   = out_keyblock_done_r;
  assign out_keyblock_signed = out_keyblock_signed_r;
  assign out_table_overflow  = out_table_overflow_r;

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n)
      table_count_r <= ucc_pkg::TBL_FULL;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("table fill count beyond depth");

  property p_full_marg_excl;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r |-> !(out_uid_full_r && out_uid_marginal_r);
  endproperty
  a_full_marg_excl: assert property (p_full_marg_excl)
    else $error("user ID reported both full and marginal");

  property p_signed_on_end;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_keyblock_signed_r) |-> out_keyblock_done_r;
  endproperty
  a_signed_on_end: assert property (p_signed_on_end)
    else $error("keyblock signed flag reported without keyblock end");

  property p_no_accept_in_scan;
    @(posedge clk) disable iff (!rst_n)
      lkp_start |=> !accept;
  endproperty
  a_no_accept_in_scan: assert property (p_no_accept_in_scan)
    else $error("word accepted while table scan runs");

endmodule

// File: rtl/core/ucc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucc_table
// Trusted-key table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ucc_table (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ucc_pkg::TBL_AW-1:0] wr_addr,
  input  ucc_pkg::tbl_entry_t        wr_data,
  input  logic                       rd_en,
  input  logic [ucc_pkg::TBL_AW-1:0] rd_addr,
  output ucc_pkg::tbl_entry_t        rd_data
);

  ucc_pkg::tbl_entry_t mem [ucc_pkg::TABLE_DEPTH];
  ucc_pkg::tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ucc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucc_lookup
// Sequential first-match search of the trusted-key table for one issuer.
// One entry is read per cycle; the compare runs on the registered read data.
// ----------------------------------------------------------------------------
module ucc_lookup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ucc_pkg::KEY_W-1:0]     key,
  input  logic [ucc_pkg::TBL_CNT_W-1:0] count,
  input  ucc_pkg::tbl_entry_t           rd_data,
  output logic                          rd_en,
  output logic [ucc_pkg::TBL_AW-1:0]    rd_addr,
  output ucc_pkg::lkp_status_t          status
);

  ucc_pkg::lkp_state_t            state_r, state_nxt;
  logic [ucc_pkg::TBL_CNT_W-1:0]  idx_r, idx_nxt;
  logic [ucc_pkg::KEY_W-1:0]      key_r;
  logic                           hit;
  logic                           last;

  assign hit  = (state_r == ucc_pkg::LKP_SCAN) && (rd_data.id == key_r);
  assign last = (idx_r == count);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ucc_pkg::LKP_IDLE: begin
        if (start) begin
          state_nxt = ucc_pkg::LKP_SCAN;
        end
      end
      ucc_pkg::LKP_SCAN: begin
        if (hit || last) begin
          state_nxt = ucc_pkg::LKP_IDLE;
        end
      end
      default: state_nxt = ucc_pkg::LKP_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    idx_nxt      = idx_r;
    status.busy  = 1'b0;
    status.done  = 1'b0;
    status.hit   = 1'b0;
    status.level = rd_data.level;
    unique case (state_r)
      ucc_pkg::LKP_IDLE: begin
        rd_en   = start;
        idx_nxt = ucc_pkg::TBL_CNT_W'(1);
      end
      ucc_pkg::LKP_SCAN: begin
        status.busy = 1'b1;
        status.done = hit || last;
        status.hit  = hit;
        rd_en       = !(hit || last);
        rd_addr     = idx_r[ucc_pkg::TBL_AW-1:0];
        if (!(hit || last)) begin
          idx_nxt = idx_r + ucc_pkg::TBL_CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucc_pkg::LKP_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == ucc_pkg::LKP_IDLE) begin
      key_r <= key;
    end
  end

  property p_start_scans;
    @(posedge clk) disable iff (!rst_n)
      (start && state_r == ucc_pkg::LKP_IDLE) |=> (state_r == ucc_pkg::LKP_SCAN);
  endproperty
  a_start_scans: assert property (p_start_scans)
    else $error("lookup did not enter scan after start");

  property p_idx_bound;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ucc_pkg::LKP_SCAN) |-> (idx_r <= count && idx_r != '0);
  endproperty
  a_idx_bound: assert property (p_idx_bound)
    else $error("lookup index outside table fill");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the user-ID certification counter. A behavioral
// predictor tracks the trusted-key table and the keyblock state, queues the
// report word every accepted word should cause, and a checker compares each
// report word field by field. Directed sequences cover the corner cases, the
// table overflow and count saturation; random keyblocks then run under a
// sweep of threshold settings, with random gaps on both channels where enabled.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int POOL_SIZE      = 12;

  localparam logic [ucc_pkg::OP_W-1:0]  OP_RSVD_6     = 3'd6;
  localparam logic [ucc_pkg::OP_W-1:0]  OP_RSVD_7     = 3'd7;
  localparam logic [ucc_pkg::LVL_W-1:0] LVL_UNKNOWN   = 3'd0;
  localparam logic [ucc_pkg::LVL_W-1:0] LVL_UNDEFINED = 3'd1;
  localparam logic [ucc_pkg::LVL_W-1:0] LVL_RSVD      = 3'd7;

  localparam logic [ucc_pkg::KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_ONES = '1;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_A    = 64'h0123_4567_89ab_cdef;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_B    = 64'h8000_0000_0000_0001;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_C    = 64'h7fff_ffff_ffff_fffe;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_P    = 64'hfedc_ba98_7654_3210;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_F    = 64'h5555_5555_5555_5555;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_M    = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic [ucc_pkg::KEY_W-1:0] KEY_U    = 64'h0f0f_0f0f_0f0f_0f0f;

  typedef struct packed {
    logic                      uid_present;
    logic [ucc_pkg::CNT_W-1:0] uid_number;
    logic                      uid_signed;
    logic                      uid_marginal;
    logic                      uid_full;
    logic                      kb_done;
    logic                      keyblock_signed;
    logic                      overflow;
  } validity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ucc_pkg::OP_W-1:0]      in_op = '0;
  logic [ucc_pkg::KEY_W-1:0]     in_key_id = '0;
  logic [ucc_pkg::LVL_W-1:0]     in_trust_level = '0;
  logic                          in_is_certification = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_uid_present;
  logic [ucc_pkg::CNT_W-1:0]     out_uid_number;
  logic                          out_uid_signed;
  logic                          out_uid_marginal;
  logic                          out_uid_full;
  logic                          out_keyblock_done;
  logic                          out_keyblock_signed;
  logic                          out_table_overflow;
  logic                          cfg_we = 1'b0;
  logic [ucc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ucc_pkg::CNT_W-1:0]     cfg_data = '0;

  // predictor state
  logic [ucc_pkg::KEY_W-1:0] trust_ids [ucc_pkg::TABLE_DEPTH];
  logic [ucc_pkg::LVL_W-1:0] trust_lvls [ucc_pkg::TABLE_DEPTH];
  int unsigned               trust_fill = 0;
  logic                      ovf_sticky = 1'b0;
  logic [ucc_pkg::KEY_W-1:0] primary_key = '0;
  logic                      uid_is_open = 1'b0;
  logic [ucc_pkg::CNT_W-1:0] uid_seq = '0;
  logic                      uid_signed_now = 1'b0;
  logic [ucc_pkg::CNT_W-1:0] n_full = '0;
  logic [ucc_pkg::CNT_W-1:0] n_marginal = '0;
  logic                      kb_signed = 1'b0;
  logic [ucc_pkg::CNT_W-1:0] thr_full = ucc_pkg::FULL_NEEDED_RST;
  logic [ucc_pkg::CNT_W-1:0] thr_marg = ucc_pkg::MARGINAL_NEEDED_RST;

  validity_t                 reports_due [$];
  logic [ucc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned               words_sent = 0;
  int unsigned               errors = 0;
  int unsigned               idle_cycles = 0;
  int unsigned               stall_left = 0;
  bit                        idle_on = 1'b1;

  always #(CLK_HALF) clk = ~clk;

  uid_certification_counter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_key_id           (in_key_id),
    .in_trust_level      (in_trust_level),
    .in_is_certification (in_is_certification),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_uid_present     (out_uid_present),
    .out_uid_number      (out_uid_number),
    .out_uid_signed      (out_uid_signed),
    .out_uid_marginal    (out_uid_marginal),
    .out_uid_full        (out_uid_full),
    .out_keyblock_done   (out_keyblock_done),
    .out_keyblock_signed (out_keyblock_signed),
    .out_table_overflow  (out_table_overflow),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ucc_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ucc_pkg::LVL_W-1:0] rand_lvl();
    return ucc_pkg::LVL_W'($urandom_range(0, 7));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void drop_uid_counts();
    uid_signed_now = 1'b0;
    n_full = '0;
    n_marginal = '0;
  endfunction

  function automatic validity_t close_uid();
    validity_t r;
    r = '0;
    r.uid_present = 1'b1;
    r.uid_number = uid_seq;
    r.uid_signed = uid_signed_now;
    r.uid_full = uid_signed_now && (n_full >= thr_full || n_marginal >= thr_marg);
    r.uid_marginal = uid_signed_now && !r.uid_full && (n_full != '0 || n_marginal != '0);
    if (uid_signed_now) kb_signed = 1'b1;
    return r;
  endfunction

  function automatic void predict_validity(input logic [ucc_pkg::OP_W-1:0] op,
                                           input logic [ucc_pkg::KEY_W-1:0] kid,
                                           input logic [ucc_pkg::LVL_W-1:0] lvl,
                                           input logic cert);
    validity_t res;
    logic [ucc_pkg::LVL_W-1:0] hit_lvl;
    res = '0;
    case (op)
      ucc_pkg::OP_CLEAR: trust_fill = 0;
      ucc_pkg::OP_APPEND: begin
        if (trust_fill < ucc_pkg::TABLE_DEPTH) begin
          trust_ids[trust_fill[ucc_pkg::TBL_AW-1:0]] = kid;
          trust_lvls[trust_fill[ucc_pkg::TBL_AW-1:0]] = lvl;
          trust_fill++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
      ucc_pkg::OP_BEGIN: begin
        primary_key = kid;
        uid_is_open = 1'b0;
        uid_seq = '0;
        drop_uid_counts();
        kb_signed = 1'b0;
      end
      ucc_pkg::OP_UID: begin
        if (uid_is_open) begin
          res = close_uid();
          res.overflow = ovf_sticky;
          reports_due.push_back(res);
          if (uid_seq != ucc_pkg::CNT_MAX) uid_seq++;
        end else begin
          uid_is_open = 1'b1;
          uid_seq = '0;
        end
        drop_uid_counts();
      end
      ucc_pkg::OP_SIG: begin
        if (kid != primary_key && cert) begin
          // first match in table order wins
          for (int i = 0; i < trust_fill; i++) begin
            if (trust_ids[i[ucc_pkg::TBL_AW-1:0]] == kid) begin
              hit_lvl = trust_lvls[i[ucc_pkg::TBL_AW-1:0]];
              if (hit_lvl == ucc_pkg::LVL_ULTIMATE) n_full = thr_full;
              else if (hit_lvl == ucc_pkg::LVL_FULLY && n_full != ucc_pkg::CNT_MAX) n_full++;
              else if (hit_lvl == ucc_pkg::LVL_MARGINAL && n_marginal != ucc_pkg::CNT_MAX)
                n_marginal++;
              uid_signed_now = 1'b1;
              break;
            end
          end
        end
      end
      ucc_pkg::OP_END: begin
        if (uid_is_open) res = close_uid();
        res.kb_done = 1'b1;
        res.keyblock_signed = kb_signed;
        res.overflow = ovf_sticky;
        reports_due.push_back(res);
        uid_is_open = 1'b0;
        uid_seq = '0;
        drop_uid_counts();
        kb_signed = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [ucc_pkg::CNT_W-1:0] got,
                             input logic [ucc_pkg::CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // hold the word until accepted, then advance the predictor
  task automatic send_word(input logic [ucc_pkg::OP_W-1:0] op,
                           input logic [ucc_pkg::KEY_W-1:0] kid,
                           input logic [ucc_pkg::LVL_W-1:0] lvl, input logic cert);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_id <= kid;
    in_trust_level <= lvl;
    in_is_certification <= cert;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_validity(op, kid, lvl, cert);
    words_sent++;
  endtask

  task automatic send_sig(input logic [ucc_pkg::KEY_W-1:0] prim);
    int unsigned r;
    logic [ucc_pkg::KEY_W-1:0] issuer;
    r = $urandom_range(0, 99);
    if (r < 70) issuer = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 80) issuer = prim;
    else issuer = rand_key();
    send_word(ucc_pkg::OP_SIG, issuer, rand_lvl(), $urandom_range(0, 99) < 85);
  endtask

  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    // let a table scan with no report finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [ucc_pkg::CNT_W-1:0] full,
                                    input logic [ucc_pkg::CNT_W-1:0] marg);
    quiesce();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ucc_pkg::REG_FULL_NEEDED;
    cfg_data <= full;
    @(negedge clk);
    cfg_index <= ucc_pkg::REG_MARGINAL_NEEDED;
    cfg_data <= marg;
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_full = full;
    thr_marg = marg;
  endtask

  task automatic test_directed();
    send_word(ucc_pkg::OP_END, rand_key(), rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_CLEAR, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_ZERO, ucc_pkg::LVL_FULLY, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_ONES, ucc_pkg::LVL_ULTIMATE, 1'b1);
    send_word(ucc_pkg::OP_APPEND, KEY_A, ucc_pkg::LVL_MARGINAL, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_A, ucc_pkg::LVL_FULLY, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_B, LVL_RSVD, 1'b1);
    send_word(ucc_pkg::OP_APPEND, KEY_C, LVL_UNKNOWN, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_P, LVL_UNDEFINED, 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_ZERO, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_A, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_BEGIN, KEY_P, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, KEY_A, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_P, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, KEY_ONES, rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_ONES, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, KEY_B, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, KEY_C, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, rand_key(), rand_lvl(), 1'b1);
    send_word(OP_RSVD_6, KEY_ONES, LVL_RSVD, 1'b1);
    send_word(OP_RSVD_7, KEY_ONES, ucc_pkg::LVL_ULTIMATE, 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_BEGIN, KEY_P, rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_ZERO, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_END, rand_key(), rand_lvl(), 1'b0);
  endtask

  task automatic test_table_overflow();
    logic [ucc_pkg::KEY_W-1:0] last_key;
    send_word(ucc_pkg::OP_CLEAR, rand_key(), rand_lvl(), 1'b1);
    repeat (ucc_pkg::TABLE_DEPTH) begin
      last_key = rand_key();
      send_word(ucc_pkg::OP_APPEND, last_key, rand_lvl(), rand_bit());
    end
    repeat (3) send_word(ucc_pkg::OP_APPEND, KEY_ONES, ucc_pkg::LVL_ULTIMATE, 1'b1);
    send_word(ucc_pkg::OP_BEGIN, KEY_P, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, last_key, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, KEY_ONES, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_SIG, rand_key(), rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_END, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_CLEAR, rand_key(), rand_lvl(), 1'b0);
  endtask

  task automatic test_saturation();
    program_thresholds(ucc_pkg::CNT_MAX, ucc_pkg::CNT_MAX);
    send_word(ucc_pkg::OP_CLEAR, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_F, ucc_pkg::LVL_FULLY, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_M, ucc_pkg::LVL_MARGINAL, 1'b0);
    send_word(ucc_pkg::OP_APPEND, KEY_U, ucc_pkg::LVL_ULTIMATE, 1'b0);
    send_word(ucc_pkg::OP_BEGIN, KEY_P, rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    repeat (3) send_word(ucc_pkg::OP_SIG, KEY_F, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    repeat (257) send_word(ucc_pkg::OP_SIG, KEY_M, rand_lvl(), 1'b1);
    send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), 1'b0);
    send_word(ucc_pkg::OP_SIG, KEY_U, rand_lvl(), 1'b1);
    repeat (2) send_word(ucc_pkg::OP_SIG, KEY_F, rand_lvl(), 1'b1);
    repeat (257) send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), rand_bit());
    send_word(ucc_pkg::OP_END, rand_key(), rand_lvl(), 1'b0);
  endtask

  task automatic test_random_keyblocks(input int unsigned n_words);
    int unsigned first;
    int unsigned r;
    logic [ucc_pkg::KEY_W-1:0] prim;
    logic [ucc_pkg::LVL_W-1:0] lvl;
    first = words_sent;
    while (words_sent - first < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(ucc_pkg::OP_W'($urandom_range(0, 7)), rand_key(), rand_lvl(), rand_bit());
      end else if (r < 18) begin
        if ($urandom_range(0, 4) != 0)
          send_word(ucc_pkg::OP_CLEAR, rand_key(), rand_lvl(), 1'b0);
        repeat ($urandom_range(0, 12)) begin
          r = $urandom_range(0, 99);
          if (r < 30) lvl = ucc_pkg::LVL_MARGINAL;
          else if (r < 55) lvl = ucc_pkg::LVL_FULLY;
          else if (r < 65) lvl = ucc_pkg::LVL_ULTIMATE;
          else lvl = rand_lvl();
          send_word(ucc_pkg::OP_APPEND, key_pool[$urandom_range(0, POOL_SIZE - 1)], lvl,
                    rand_bit());
        end
      end else begin
        prim = ($urandom_range(0, 4) == 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : rand_key();
        if ($urandom_range(0, 9) != 0)
          send_word(ucc_pkg::OP_BEGIN, prim, rand_lvl(), rand_bit());
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_sig(prim);
        repeat ($urandom_range(0, 5)) begin
          send_word(ucc_pkg::OP_UID, rand_key(), rand_lvl(), rand_bit());
          repeat ($urandom_range(0, 8)) send_sig(prim);
        end
        if ($urandom_range(0, 9) != 0)
          send_word(ucc_pkg::OP_END, rand_key(), rand_lvl(), rand_bit());
      end
    end
  endtask

  task automatic run_setting(input logic [ucc_pkg::CNT_W-1:0] full,
                             input logic [ucc_pkg::CNT_W-1:0] marg,
                             input bit with_gaps);
    program_thresholds(full, marg);
    idle_on = with_gaps;
    test_random_keyblocks(30);
  endtask

  // result-side stall: random runs, none while gaps are off
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    validity_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        report_mismatch("report word with nothing expected");
      end else begin
        want = reports_due.pop_front();
        check_flag("uid_present", out_uid_present, want.uid_present);
        check_field("uid_number", out_uid_number, want.uid_number);
        check_flag("uid_signed", out_uid_signed, want.uid_signed);
        check_flag("uid_marginal", out_uid_marginal, want.uid_marginal);
        check_flag("uid_full", out_uid_full, want.uid_full);
        check_flag("keyblock_done", out_keyblock_done, want.kb_done);
        check_flag("keyblock_signed", out_keyblock_signed, want.keyblock_signed);
        check_flag("table_overflow", out_table_overflow, want.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_ONES;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    idle_on = 1'b0;
    test_table_overflow();
    idle_on = 1'b1;
    test_saturation();
    run_setting(8'd0, 8'd0, 1'b1);
    run_setting(8'd1, 8'd1, 1'b0);
    run_setting(ucc_pkg::CNT_MAX, ucc_pkg::CNT_MAX, 1'b1);
    run_setting(8'd2, 8'd4, 1'b1);
    run_setting(8'd1, ucc_pkg::CNT_MAX, 1'b0);
    run_setting(ucc_pkg::CNT_MAX, 8'd1, 1'b1);
    run_setting(8'd3, 8'd2, 1'b1);
    run_setting(ucc_pkg::FULL_NEEDED_RST, ucc_pkg::MARGINAL_NEEDED_RST, 1'b1);

    quiesce();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
